[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to drop
// every check from a build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at each rising clock edge, skipped while in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at each rising clock edge, skipped while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/sgag_pkg.sv]
// ----------------------------------------------------------------------------
// sgag_pkg
// Shared widths, limits and types of the strided gather address generator.
// ----------------------------------------------------------------------------
package sgag_pkg;

	localparam int MAX_RANK   = 8;
	localparam int DIM_IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int RANK_CNT_W = $clog2(MAX_RANK + 1);

	localparam int SIZE_W   = 16;
	localparam int STRIDE_W = 32;
	localparam int BASE_W   = 40;
	localparam int EB_W     = 4;
	localparam int RANK_W   = 4;
	localparam int ADDR_W   = 56;
	localparam int ELEM_W   = 48;
	localparam int PROD_W   = SIZE_W + STRIDE_W;

	// Request codes carried on req_type.
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_STEP  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Configuration register indexes; each register sits at eight times its index.
	typedef enum logic [1:0] {
		REG_ELEM_BYTES  = 2'd0,
		REG_BASE_OFFSET = 2'd1,
		REG_RANK        = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	// Control of the shared multiply-add unit.
	typedef struct packed {
		logic load;    // start a new sum from the base offset
		logic acc_en;  // add one index times stride term
	} mac_ctrl_t;

endpackage

[src/sgag_mac.sv]
// ----------------------------------------------------------------------------
// sgag_mac
// Shared multiply-add unit: accumulates index times stride terms, one
// dimension per cycle, on top of the view's base offset.
// ----------------------------------------------------------------------------
module sgag_mac import sgag_pkg::*; (
	input  logic                clk,
	input  mac_ctrl_t           ctrl,
	input  logic [BASE_W-1:0]   base,
	input  logic [SIZE_W-1:0]   idx,
	input  logic [STRIDE_W-1:0] stride,
	output logic [ADDR_W-1:0]   acc
);

	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] acc_q;

	assign prod = PROD_W'(idx) * PROD_W'(stride);

	// The sum wraps modulo the address width, as the addresses do.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= ADDR_W'(base);
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ADDR_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

[src/strided_gather_address_gen.sv]
// ----------------------------------------------------------------------------
// strided_gather_address_gen
// Source and dense destination byte addresses for gathering a strided view.
// ----------------------------------------------------------------------------
// A load or start beat never raises busy. A step beat that has an element
// to emit keeps busy high while the block walks its states: in ST_ACCUM one
// shared multiply-add unit folds one dimension per cycle into the source
// offset (rank clamped to the supported maximum), then ST_FINISH scales both
// addresses by the element size and advances the index odometer, and
// result_strobe and the addresses are registered from ST_FINISH. A step
// with nothing left to walk never raises busy and gives no result. Each
// result is shown for one cycle only, so the receiver must take it when
// result_strobe is high.
module strided_gather_address_gen import sgag_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Request channel
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic [2:0]          dim_select,
	input  logic [SIZE_W-1:0]   dim_size,
	input  logic [STRIDE_W-1:0] dim_stride,
	// Result channel
	output logic                result_strobe,
	output logic [ADDR_W-1:0]   src_byte_addr,
	output logic [ADDR_W-1:0]   dst_byte_addr,
	output logic                last,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [EB_W-1:0]      elem_bytes_q;
	logic [BASE_W-1:0]    base_offset_q;
	logic [RANK_W-1:0]    rank_q;
	logic [SIZE_W-1:0]    sizes_q   [MAX_RANK];
	logic [STRIDE_W-1:0]  strides_q [MAX_RANK];
	logic [SIZE_W-1:0]    idx_q     [MAX_RANK];
	logic [ELEM_W-1:0]    elem_num_q;
	logic                 walk_done_q;
	logic [DIM_IDX_W-1:0] dim_q;
	logic                 strobe_q;
	logic [ADDR_W-1:0]    src_q;
	logic [ADDR_W-1:0]    dst_q;
	logic                 last_q;

	logic                  accept;
	logic                  cfg_write;
	reg_idx_t              cfg_idx;
	req_t                  req;
	logic [RANK_CNT_W-1:0] rank_act;
	logic [DIM_IDX_W-1:0]  sel_idx;
	logic                  sel_ok;
	logic                  empty_walk;
	mac_ctrl_t             mac_ctrl;
	logic [ADDR_W-1:0]     acc;
	logic [ADDR_W+EB_W-1:0] src_full;
	logic [ELEM_W+EB_W-1:0] dst_full;
	logic [SIZE_W-1:0]     idx_next [MAX_RANK];
	logic                  carry_out;
	logic                  last_dim;

	assign accept    = start && !busy;
	assign req       = req_t'(req_type);
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[4:3]);
	assign pready    = 1'b1;

	assign rank_act = (32'(rank_q) > MAX_RANK) ? RANK_CNT_W'(MAX_RANK)
		: RANK_CNT_W'(rank_q);
	assign sel_ok   = 32'(dim_select) < MAX_RANK;
	assign sel_idx  = DIM_IDX_W'(dim_select);
	assign last_dim = (RANK_CNT_W'(dim_q) + RANK_CNT_W'(1)) == rank_act;

	always_comb begin
		unique case (cfg_idx)
			REG_ELEM_BYTES:  prdata = 64'(elem_bytes_q);
			REG_BASE_OFFSET: prdata = 64'(base_offset_q);
			REG_RANK:        prdata = 64'(rank_q);
			default:         prdata = '0;
		endcase
	end

	// A walk is empty when any dimension in use has zero extent.
	always_comb begin
		empty_walk = 1'b0;
		for (int d = 0; d < MAX_RANK; d++) begin
			if ((RANK_CNT_W'(d) < rank_act) && (sizes_q[d] == '0)) begin
				empty_walk = 1'b1;
			end
		end
	end

	// Odometer: innermost dimension first; a dimension advances only when all
	// inner ones wrapped. An index at or past its extent wraps to zero.
	always_comb begin
		carry_out = 1'b1;
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			idx_next[d] = idx_q[d];
			if ((RANK_CNT_W'(d) < rank_act) && carry_out) begin
				if (({1'b0, idx_q[d]} + 17'd1) < {1'b0, sizes_q[d]}) begin
					idx_next[d] = idx_q[d] + SIZE_W'(1);
					carry_out   = 1'b0;
				end else begin
					idx_next[d] = '0;
				end
			end
		end
	end

	assign mac_ctrl.load   = accept && (req == REQ_STEP) && !walk_done_q;
	assign mac_ctrl.acc_en = (state_q == ST_ACCUM);

	sgag_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.base   (base_offset_q),
		.idx    (idx_q[dim_q]),
		.stride (strides_q[dim_q]),
		.acc    (acc)
	);

	assign src_full = (ADDR_W + EB_W)'(acc) * (ADDR_W + EB_W)'(elem_bytes_q);
	assign dst_full = (ELEM_W + EB_W)'(elem_num_q) * (ELEM_W + EB_W)'(elem_bytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			elem_bytes_q  <= EB_W'(4);
			base_offset_q <= '0;
			rank_q        <= '0;
			for (int d = 0; d < MAX_RANK; d++) begin
				sizes_q[d]   <= '0;
				strides_q[d] <= '0;
				idx_q[d]     <= '0;
			end
			elem_num_q    <= '0;
			walk_done_q   <= 1'b1;
			dim_q         <= '0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;

			if (cfg_write) begin
				unique case (cfg_idx)
					REG_ELEM_BYTES:  elem_bytes_q  <= pwdata[EB_W-1:0];
					REG_BASE_OFFSET: base_offset_q <= pwdata[BASE_W-1:0];
					REG_RANK:        rank_q        <= pwdata[RANK_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_LOAD: begin
								if (sel_ok) begin
									sizes_q[sel_idx]   <= dim_size;
									strides_q[sel_idx] <= dim_stride;
								end
							end
							REQ_START: begin
								for (int d = 0; d < MAX_RANK; d++) begin
									idx_q[d] <= '0;
								end
								elem_num_q  <= '0;
								walk_done_q <= empty_walk;
							end
							REQ_STEP: begin
								if (!walk_done_q) begin
									dim_q   <= '0;
									state_q <= (rank_act == '0) ? ST_FINISH : ST_ACCUM;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ACCUM: begin
					if (last_dim) begin
						state_q <= ST_FINISH;
					end else begin
						dim_q <= dim_q + DIM_IDX_W'(1);
					end
				end
				ST_FINISH: begin
					for (int d = 0; d < MAX_RANK; d++) begin
						idx_q[d] <= idx_next[d];
					end
					walk_done_q <= carry_out;
					elem_num_q  <= elem_num_q + ELEM_W'(1);
					strobe_q    <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload is only meaningful while the strobe is high.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			src_q  <= src_full[ADDR_W-1:0];
			dst_q  <= ADDR_W'(dst_full);
			last_q <= carry_out;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign src_byte_addr = src_q;
	assign dst_byte_addr = dst_q;
	assign last          = last_q;

	`ASSERT_IMPL(a_strobe_single, clk, arst_n, result_strobe, ##1 !result_strobe, "strobe held")
	`ASSERT_IMPL(a_strobe_from_finish, clk, arst_n, result_strobe, $past(state_q == ST_FINISH), "stray result")
	`ASSERT_IMPL(a_last_ends_walk, clk, arst_n, result_strobe && last, walk_done_q, "walk not ended")
	`ASSERT_IMPL(a_done_step_idle, clk, arst_n, accept && (req == REQ_STEP) && walk_done_q, ##1 (state_q == ST_IDLE), "idle step busy")

endmodule

[test/strided_gather_address_gen_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_gather_address_gen_tb
// Self-checking bench for the strided gather address generator. Dimension
// loads, walk starts and steps go in through the start/busy handshake with
// random gaps, and the element size, base offset and rank are rewritten
// through the APB port between phases. A scoreboard keeps its own copy of
// the dimension tables and the index odometer, predicts every source and
// destination address and the last flag, and compares each strobed result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module strided_gather_address_gen_tb import sgag_pkg::*; ();

	localparam logic [4:0] ADDR_ELEM_BYTES  = {REG_ELEM_BYTES, 3'b000};
	localparam logic [4:0] ADDR_BASE_OFFSET = {REG_BASE_OFFSET, 3'b000};
	localparam logic [4:0] ADDR_RANK        = {REG_RANK, 3'b000};

	localparam int          TARGET_ITEMS = 1200;
	localparam int          SETTLE       = MAX_RANK + 6;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [63:0] ADDR_MASK    = (64'd1 << ADDR_W) - 64'd1;

	typedef struct {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic              lst;
	} gather_beat_t;

	class gather_scoreboard;
		logic [EB_W-1:0]     elem_bytes;
		logic [BASE_W-1:0]   base_offset;
		logic [RANK_W-1:0]   rank;
		logic [SIZE_W-1:0]   sizes[MAX_RANK];
		logic [STRIDE_W-1:0] strides[MAX_RANK];
		logic [SIZE_W-1:0]   idx[MAX_RANK];
		logic [ELEM_W-1:0]   elem_num;
		bit                  walk_done;
		gather_beat_t        expected_beats[$];
		int unsigned         errors;

		function new();
			elem_bytes  = 4'd4;
			base_offset = '0;
			rank        = '0;
			foreach (sizes[d]) begin
				sizes[d]   = '0;
				strides[d] = '0;
				idx[d]     = '0;
			end
			elem_num  = '0;
			walk_done = 1'b1;
			errors    = 0;
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return expected_beats.size();
		endfunction

		function void write_reg(logic [4:0] addr, logic [63:0] data);
			case (addr)
				ADDR_ELEM_BYTES:  elem_bytes  = data[EB_W-1:0];
				ADDR_BASE_OFFSET: base_offset = data[BASE_W-1:0];
				ADDR_RANK:        rank        = data[RANK_W-1:0];
				default: ;
			endcase
		endfunction

		// Advances the walk by one accepted beat and queues the address pair
		// that a productive step must produce.
		function void note_request(req_t req, logic [2:0] sel,
				logic [SIZE_W-1:0] size, logic [STRIDE_W-1:0] stride);
			int           r;
			int           d;
			logic [63:0]  off;
			gather_beat_t beat;
			bit           carry;
			r = (rank > MAX_RANK) ? MAX_RANK : int'(rank);
			case (req)
				REQ_LOAD: begin
					if (sel < MAX_RANK) begin
						sizes[sel]   = size;
						strides[sel] = stride;
					end
				end
				REQ_START: begin
					foreach (idx[k]) idx[k] = '0;
					walk_done = 1'b0;
					for (d = 0; d < r; d++)
						if (sizes[d] == '0) walk_done = 1'b1;
					elem_num = '0;
				end
				REQ_STEP: begin
					if (!walk_done) begin
						off = 64'(base_offset);
						for (d = 0; d < r; d++)
							off += 64'(idx[d]) * 64'(strides[d]);
						off &= ADDR_MASK;
						beat.src = ADDR_W'(off * 64'(elem_bytes));
						beat.dst = ADDR_W'(64'(elem_num) * 64'(elem_bytes));
						// Innermost dimension turns fastest; an index past a
						// shrunken size wraps to zero and carries.
						carry = 1'b1;
						for (d = r - 1; d >= 0; d--) begin
							if (int'(idx[d]) + 1 < int'(sizes[d])) begin
								idx[d] = idx[d] + 1'b1;
								carry  = 1'b0;
								break;
							end
							idx[d] = '0;
						end
						beat.lst  = carry;
						walk_done = carry;
						elem_num  = elem_num + 1'b1;
						expected_beats.insert(expected_beats.size(), beat);
					end
				end
				default: ;
			endcase
		endfunction

		task check_result(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst, logic lst);
			gather_beat_t exp_beat;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected result src=%h dst=%h last=%b", src, dst, lst));
			end else begin
				exp_beat = expected_beats.pop_front();
				if (src !== exp_beat.src)
					report($sformatf("src_byte_addr %h, expected %h", src, exp_beat.src));
				if (dst !== exp_beat.dst)
					report($sformatf("dst_byte_addr %h, expected %h", dst, exp_beat.dst));
				if (lst !== exp_beat.lst)
					report($sformatf("last %b, expected %b", lst, exp_beat.lst));
			end
		endtask

		task drain_check();
			while (expected_beats.size() != 0) begin
				report($sformatf("missing result src=%h dst=%h",
					expected_beats[0].src, expected_beats[0].dst));
				void'(expected_beats.pop_front());
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          req_type;
	logic [2:0]          dim_select;
	logic [SIZE_W-1:0]   dim_size;
	logic [STRIDE_W-1:0] dim_stride;
	logic                result_strobe;
	logic [ADDR_W-1:0]   src_byte_addr;
	logic [ADDR_W-1:0]   dst_byte_addr;
	logic                last;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [4:0]          paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;

	gather_scoreboard sb;
	int unsigned      cycles;
	int               items_sent;
	bit               no_gaps;

	strided_gather_address_gen dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.dim_select    (dim_select),
		.dim_size      (dim_size),
		.dim_stride    (dim_stride),
		.result_strobe (result_strobe),
		.src_byte_addr (src_byte_addr),
		.dst_byte_addr (dst_byte_addr),
		.last          (last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// All inputs change only on nonblocking updates, so the values read here
	// are the ones the block saw at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (result_strobe)
				sb.check_result(src_byte_addr, dst_byte_addr, last);
			if (start && !busy)
				sb.note_request(req_t'(req_type), dim_select, dim_size, dim_stride);
			if (psel && penable && pwrite && pready)
				sb.write_reg(paddr, pwdata);
			if (cycles > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Drives one request beat and holds it until the block takes it. The
	// start line stays high when no gap follows.
	task send_beat(req_t req, logic [2:0] sel, logic [SIZE_W-1:0] size,
			logic [STRIDE_W-1:0] stride);
		int gap;
		start      <= 1'b1;
		req_type   <= req;
		dim_select <= sel;
		dim_size   <= size;
		dim_stride <= stride;
		do @(posedge clk); while (busy);
		if (req != REQ_NONE) items_sent++;
		if (no_gaps)
			gap = 0;
		else if ($urandom_range(0, 11) == 0)
			gap = $urandom_range(8, 40);
		else if ($urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 3);
		else
			gap = 0;
		if (gap > 0) begin
			start      <= 1'b0;
			req_type   <= 2'($urandom);
			dim_size   <= SIZE_W'($urandom);
			dim_stride <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the request side off until every predicted result has arrived
	// and any step still in flight has had time to finish.
	task wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task apb_write(logic [4:0] addr, logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [SIZE_W-1:0] loaded[MAX_RANK];
		int                r;
		int                walk_len;
		int                nsteps;
		logic [3:0]        eb_val;
		logic [3:0]        rank_val;
		logic [63:0]       base_val;
		logic [SIZE_W-1:0] sz;

		sb         = new();
		cycles     = 0;
		items_sent = 0;
		no_gaps    = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_LOAD;
		dim_select = '0;
		dim_size   = '0;
		dim_stride = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no walk after reset, unknown request, the one-element walk
		// of rank zero, then extreme sizes, strides and offsets.
		send_beat(REQ_STEP, 3'd0, '0, '0);
		send_beat(REQ_NONE, 3'd7, '1, '1);
		send_beat(REQ_START, 3'd0, '0, '0);
		send_beat(REQ_STEP, 3'd0, '0, '0);
		send_beat(REQ_STEP, 3'd0, '0, '0);
		wait_drained();
		apb_write(ADDR_ELEM_BYTES, 64'd8);
		apb_write(ADDR_BASE_OFFSET, 64'h0000_00FF_FFFF_FFFF);
		apb_write(ADDR_RANK, 64'd2);
		send_beat(REQ_LOAD, 3'd0, 16'd2, 32'hFFFF_FFFF);
		send_beat(REQ_LOAD, 3'd1, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(REQ_START, 3'd0, '0, '0);
		repeat (3) send_beat(REQ_STEP, 3'd0, '0, '0);
		// Shrink the inner dimension under the running index.
		send_beat(REQ_LOAD, 3'd1, 16'd1, 32'h8000_0001);
		repeat (3) send_beat(REQ_STEP, 3'd0, '0, '0);
		send_beat(REQ_LOAD, 3'd0, 16'd0, 32'd5);
		send_beat(REQ_START, 3'd0, '0, '0);
		send_beat(REQ_STEP, 3'd0, '0, '0);
		wait_drained();
		apb_write(ADDR_ELEM_BYTES, 64'hFFFF_FFFF_FFFF_FFF0);
		apb_write(ADDR_RANK, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(ADDR_BASE_OFFSET, 64'hFFFF_FF00_0000_0000);
		send_beat(REQ_START, 3'd0, '0, '0);
		send_beat(REQ_STEP, 3'd0, '0, '0);

		// Random phases: new settings, full dimension tables, then walks.
		while (items_sent < TARGET_ITEMS) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0:       eb_val = 4'd0;
				1:       eb_val = 4'd15;
				2:       eb_val = 4'd1;
				3:       eb_val = 4'd8;
				4:       eb_val = 4'($urandom_range(9, 14));
				default: eb_val = 4'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 4))
				0:       base_val = {$urandom, $urandom} & 64'hFFFF_FF00_0000_0000;
				1:       base_val = {$urandom, 32'hFFFF_FFFF} | 64'h0000_00FF_0000_0000;
				default: base_val = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 9))
				0:       rank_val = 4'd0;
				1:       rank_val = 4'($urandom_range(9, 15));
				2:       rank_val = 4'($urandom_range(4, 8));
				default: rank_val = 4'($urandom_range(1, 3));
			endcase
			apb_write(ADDR_ELEM_BYTES, {$urandom, 28'($urandom_range(0, 268435455)), eb_val});
			apb_write(ADDR_BASE_OFFSET, base_val);
			apb_write(ADDR_RANK, {$urandom, 28'($urandom_range(0, 268435455)), rank_val});
			no_gaps = ($urandom_range(0, 3) == 0);

			for (int d = 0; d < MAX_RANK; d++) begin
				case ($urandom_range(0, 19))
					0:       sz = '0;
					1:       sz = SIZE_W'($urandom);
					default: sz = SIZE_W'($urandom_range(1, 4));
				endcase
				loaded[d] = sz;
				send_beat(REQ_LOAD, d[2:0], sz, $urandom);
			end

			r = (rank_val > MAX_RANK) ? MAX_RANK : int'(rank_val);
			walk_len = 1;
			for (int d = 0; d < r; d++)
				walk_len = (walk_len * int'(loaded[d]) > 48) ? 48 : walk_len * int'(loaded[d]);

			repeat ($urandom_range(1, 2)) begin
				send_beat(REQ_START, 3'($urandom), SIZE_W'($urandom), $urandom);
				nsteps = walk_len + $urandom_range(0, 2);
				for (int s = 0; s < nsteps; s++) begin
					if ($urandom_range(0, 14) == 0)
						send_beat(req_t'($urandom_range(0, 3)), 3'($urandom),
							SIZE_W'($urandom), $urandom);
					if ($urandom_range(0, 39) == 0)
						wait_drained();
					send_beat(REQ_STEP, 3'($urandom), SIZE_W'($urandom), $urandom);
				end
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE) @(posedge clk);
		sb.drain_check();
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
